### rtl/tty_line_editor_defines.svh
// assertion macros for the terminal line editor
`ifndef TTY_LINE_EDITOR_DEFINES_SVH
`define TTY_LINE_EDITOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tle_pkg.sv
// shared types and constants of the terminal line editor
package tle_pkg;

  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 4;
  localparam int TDATA_W       = 16;
  localparam int PAD_W         = TDATA_W - LEN_W - BYTE_W;
  localparam int LINE_SIZE_DEF = 16;
  localparam int CFG_IDX_W     = 2;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_EDIT_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CR_TO_NEWLINE = 2'd2;

  // key codes
  localparam logic [BYTE_W-1:0] K_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] K_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] K_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] K_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] K_CTLR  = 8'h12;
  localparam logic [BYTE_W-1:0] K_CTLU  = 8'h15;
  localparam logic [BYTE_W-1:0] K_CTLZ  = 8'h1A;
  localparam logic [BYTE_W-1:0] K_BEL   = 8'h07;
  localparam logic [BYTE_W-1:0] K_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] K_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] K_R     = 8'h52;

  // output channel codes
  localparam logic CH_ECHO = 1'b0;
  localparam logic CH_LINE = 1'b1;

  typedef struct packed {
    logic              channel;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  line_length;
    logic              last;
  } tle_result_t;

endpackage

### rtl/tle_line_ram.sv
// line store: one write port, one read port with registered data
module tle_line_ram #(
  parameter int DEPTH = tle_pkg::LINE_SIZE_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tle_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tle_pkg::BYTE_W-1:0] rdata
);
  import tle_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tle_out_stage.sv
// one-word output register between the sequencer and the result stream
module tle_out_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  tle_pkg::tle_result_t        result,
  output logic                        ready,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tle_pkg::TDATA_W-1:0] m_axis_tdata,  // data_byte, line_length, zero pad
  output logic                        m_axis_tuser,  // channel
  output logic                        m_axis_tlast
);
  import tle_pkg::*;

  tle_result_t held;
  logic        valid;

  assign ready = !valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= result;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, held.line_length, held.data_byte};
  assign m_axis_tuser  = held.channel;
  assign m_axis_tlast  = held.last;

endmodule

### rtl/tty_line_editor.sv
// terminal line editor top level: key decode, edit sequencer, line store
// timing: a typed byte is taken only in idle; its echo word goes from the echo state
//   into the output register, a line byte from a store read into the output register
// the next byte is taken only once every word of the last one has entered the output
//   register, so output stalls hold off the input; an erase is one group, a line kill one per byte
// reset: sync active high; clears fill count, sequencer and output valid, sets all
//   three option registers to 1; line store contents are not cleared
module tty_line_editor #(
  parameter int LINE_SIZE = tle_pkg::LINE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // typed byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tle_pkg::BYTE_W-1:0]    s_axis_tdata,   // typed_byte
  // echo and line word stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tle_pkg::TDATA_W-1:0]   m_axis_tdata,   // data_byte, line_length, pad
  output logic                          m_axis_tuser,   // channel
  output logic                          m_axis_tlast,   // last
  // option register writes
  input  logic                          cfg_we,
  input  logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data
);
  import tle_pkg::*;

`include "tty_line_editor_defines.svh"

  localparam int CW = $clog2(LINE_SIZE);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ECHO     = 6'b000010,  // single echo word (typed byte, newline or bell)
    S_ERASE    = 6'b000100,  // backspace, space, backspace, repeated
    S_PREFIX   = 6'b001000,  // caret, R, newline ahead of a reprint
    S_LINE_RD  = 6'b010000,  // address the store
    S_LINE_OUT = 6'b100000   // hand the read byte to the output register
  } state_t;

  state_t state, state_next;

  // option registers
  logic edit_enable, echo_enable, cr_to_newline;

  // editing state and per-item working registers
  logic [CW-1:0]     fill_count, fill_count_next;
  logic [CW-1:0]     sweep_len, sweep_len_next;  // bytes to walk in the store
  logic [CW-1:0]     idx, idx_next;              // store walk position
  logic [CW-1:0]     reps, reps_next;            // erase groups still to send
  logic [1:0]        phase, phase_next;          // position in a three-word group
  logic [BYTE_W-1:0] echo_byte, echo_byte_next;
  logic              echo_last, echo_last_next;
  logic              line_after, line_after_next; // walk the store after the echo
  logic              sweep_chan, sweep_chan_next;

  // store ports
  logic              mem_we, mem_re;
  logic [CW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  // output register handshake
  logic        emit, can_emit;
  tle_result_t emit_word;

  logic              in_acc;
  logic [BYTE_W-1:0] c;
  logic              is_term, is_erase, full_hit;

  // no word is taken while reset is held
  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign c             = s_axis_tdata;
  assign is_term       = (c == K_CR) || (c == K_LF);
  assign is_erase      = (c == K_BS) || (c == K_DEL);
  // an ordinary byte that would bring the count to LINE_SIZE-1 is refused
  assign full_hit      = ({1'b0, fill_count} + 1'b1) >= (CW+1)'(LINE_SIZE - 1);

  // option writes; only bit 0 matters, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      edit_enable   <= 1'b1;
      echo_enable   <= 1'b1;
      cr_to_newline <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDIT_ENABLE:   edit_enable   <= cfg_data;
        REG_ECHO_ENABLE:   echo_enable   <= cfg_data;
        REG_CR_TO_NEWLINE: cr_to_newline <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: decode the typed byte in idle, then walk out its result words.
  // the store is written only at accept time and read only afterwards, so a
  // write and a read of the same entry never overlap
  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    sweep_len_next  = sweep_len;
    idx_next        = idx;
    reps_next       = reps;
    phase_next      = phase;
    echo_byte_next  = echo_byte;
    echo_last_next  = echo_last;
    line_after_next = line_after;
    sweep_chan_next = sweep_chan;
    mem_we          = 1'b0;
    mem_waddr       = fill_count;
    mem_wdata       = c;
    mem_re          = 1'b0;
    mem_raddr       = idx;
    emit            = 1'b0;
    emit_word       = '{channel: CH_ECHO, data_byte: K_BS, line_length: '0, last: 1'b0};

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          idx_next   = '0;
          phase_next = '0;
          if (!edit_enable || is_term) begin
            // raw byte or line terminator: store it, then give out the line
            mem_we          = 1'b1;
            if (edit_enable && cr_to_newline) begin
              mem_wdata = K_LF;
            end
            sweep_len_next  = fill_count + 1'b1;
            sweep_chan_next = CH_LINE;
            fill_count_next = '0;
            echo_byte_next  = edit_enable ? K_LF : c;
            echo_last_next  = 1'b0;
            line_after_next = 1'b1;
            state_next      = echo_enable ? S_ECHO : S_LINE_RD;
          end else if (is_erase) begin
            if (fill_count != '0) begin
              fill_count_next = fill_count - 1'b1;
              reps_next       = CW'(1);
              if (echo_enable) begin
                state_next = S_ERASE;
              end
            end
          end else if (c == K_CTLR) begin
            sweep_len_next  = fill_count;
            sweep_chan_next = CH_ECHO;
            if (echo_enable) begin
              state_next = S_PREFIX;
            end
          end else if (c == K_CTLU) begin
            reps_next       = fill_count;
            fill_count_next = '0;
            if (echo_enable && (fill_count != '0)) begin
              state_next = S_ERASE;
            end
          end else begin
            // ordinary byte
            mem_we          = 1'b1;
            echo_last_next  = 1'b1;
            line_after_next = 1'b0;
            if (full_hit) begin
              echo_byte_next = K_BEL;
              state_next     = S_ECHO;
            end else begin
              fill_count_next = fill_count + 1'b1;
              echo_byte_next  = c;
              if (echo_enable && (c != K_CTLZ)) begin
                state_next = S_ECHO;
              end
            end
          end
        end
      end

      S_ECHO: begin
        emit      = 1'b1;
        emit_word = '{channel: CH_ECHO, data_byte: echo_byte, line_length: '0,
                      last: echo_last};
        if (can_emit) begin
          state_next = line_after ? S_LINE_RD : S_IDLE;
        end
      end

      S_ERASE: begin
        emit      = 1'b1;
        emit_word = '{channel: CH_ECHO, data_byte: (phase == 2'd1) ? K_SPACE : K_BS,
                      line_length: '0, last: (phase == 2'd2) && (reps == CW'(1))};
        if (can_emit) begin
          if (phase == 2'd2) begin
            phase_next = '0;
            reps_next  = reps - 1'b1;
            if (reps == CW'(1)) begin
              state_next = S_IDLE;
            end
          end else begin
            phase_next = phase + 1'b1;
          end
        end
      end

      S_PREFIX: begin
        emit = 1'b1;
        emit_word = '{channel: CH_ECHO,
                      data_byte: (phase == 2'd0) ? K_CARET : ((phase == 2'd1) ? K_R : K_LF),
                      line_length: '0, last: (phase == 2'd2) && (sweep_len == '0)};
        if (can_emit) begin
          if (phase == 2'd2) begin
            state_next = (sweep_len == '0) ? S_IDLE : S_LINE_RD;
          end else begin
            phase_next = phase + 1'b1;
          end
        end
      end

      S_LINE_RD: begin
        mem_re     = 1'b1;
        state_next = S_LINE_OUT;
      end

      S_LINE_OUT: begin
        emit      = 1'b1;
        emit_word = '{channel: sweep_chan, data_byte: mem_rdata,
                      line_length: (sweep_chan == CH_LINE) ? LEN_W'(sweep_len) : '0,
                      last: idx == (sweep_len - 1'b1)};
        if (can_emit) begin
          if (idx == (sweep_len - 1'b1)) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_LINE_RD;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    sweep_len  <= sweep_len_next;
    idx        <= idx_next;
    reps       <= reps_next;
    phase      <= phase_next;
    echo_byte  <= echo_byte_next;
    echo_last  <= echo_last_next;
    line_after <= line_after_next;
    sweep_chan <= sweep_chan_next;
  end

  tle_line_ram #(
    .DEPTH (LINE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register lets the next byte be taken while a word waits
  tle_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (emit),
    .result        (emit_word),
    .ready         (can_emit),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // raw bytes always flush the line
  `TLE_ASSERT_NEXT(a_raw_flush, in_acc && !edit_enable, fill_count == '0, "raw byte left data in the line store")
  // a line is never empty, so a terminator always starts an emission
  `TLE_ASSERT_NEXT(a_term_busy, in_acc && edit_enable && is_term, state != S_IDLE, "terminator produced no line")
  // nothing is pushed to the output while a new byte may be taken
  `TLE_ASSERT_NOW(a_idle_quiet, s_axis_tready, !emit, "emission while idle")
  // the count never reaches the store size
  `TLE_ASSERT_NOW(a_count_range, in_acc, {1'b0, fill_count} < (CW+1)'(LINE_SIZE - 1), "fill count out of range")

endmodule

### tb/tty_line_editor_checker.sv
// checker for the terminal line editor: predicts echo and line words, compares them
module tty_line_editor_checker #(
  parameter int LINE_SIZE = tle_pkg::LINE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [tle_pkg::BYTE_W-1:0]    s_axis_tdata,   // typed_byte
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [tle_pkg::TDATA_W-1:0]   m_axis_tdata,   // data_byte, line_length, pad
  input  logic                          m_axis_tuser,   // channel
  input  logic                          m_axis_tlast,   // last
  input  logic                          cfg_we,
  input  logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  output int                            errors,
  output int                            pending
);
  import tle_pkg::*;

  logic [BYTE_W-1:0] line_buf [LINE_SIZE];
  int                line_fill;
  logic              opt_edit;
  logic              opt_echo;
  logic              opt_crnl;
  tle_result_t       key_words[$];
  tle_result_t       expected_words[$];
  int                fail_count   = 0;

  function automatic void add_word(logic ch, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] len);
    tle_result_t w;
    w.channel     = ch;
    w.data_byte   = b;
    w.line_length = len;
    w.last        = 1'b0;
    key_words.push_back(w);
  endfunction

  function automatic void add_rubout();
    add_word(CH_ECHO, K_BS, '0);
    add_word(CH_ECHO, K_SPACE, '0);
    add_word(CH_ECHO, K_BS, '0);
  endfunction

  function automatic void store_byte(logic [BYTE_W-1:0] b);
    if (line_fill < LINE_SIZE) begin
      line_buf[line_fill] = b;
      line_fill++;
    end
  endfunction

  function automatic void emit_line();
    for (int i = 0; i < line_fill && i < LINE_SIZE; i++)
      add_word(CH_LINE, line_buf[i], LEN_W'(line_fill));
    line_fill = 0;
  endfunction

  function automatic void predict_key(logic [BYTE_W-1:0] key);
    tle_result_t w;
    key_words.delete();
    if (!opt_edit) begin
      store_byte(key);
      if (opt_echo) add_word(CH_ECHO, key, '0);
      emit_line();
    end else if (key == K_CR || key == K_LF) begin
      store_byte(opt_crnl ? K_LF : key);
      if (opt_echo) add_word(CH_ECHO, K_LF, '0);
      emit_line();
    end else if (key == K_BS || key == K_DEL) begin
      if (line_fill != 0) begin
        line_fill--;
        if (opt_echo) add_rubout();
      end
    end else if (key == K_CTLR) begin
      if (opt_echo) begin
        add_word(CH_ECHO, K_CARET, '0);
        add_word(CH_ECHO, K_R, '0);
        add_word(CH_ECHO, K_LF, '0);
        for (int i = 0; i < line_fill && i < LINE_SIZE; i++)
          add_word(CH_ECHO, line_buf[i], '0);
      end
    end else if (key == K_CTLU) begin
      if (opt_echo)
        for (int i = 0; i < line_fill; i++) add_rubout();
      line_fill = 0;
    end else begin
      // store full: bell goes out regardless of echo
      store_byte(key);
      if (line_fill >= LINE_SIZE - 1) begin
        add_word(CH_ECHO, K_BEL, '0);
        line_fill--;
      end else if (opt_echo && key != K_CTLZ) begin
        add_word(CH_ECHO, key, '0);
      end
    end
    foreach (key_words[i]) begin
      w      = key_words[i];
      w.last = (i == key_words.size() - 1);
      expected_words.push_back(w);
    end
  endfunction

  always @(posedge clk) begin : monitor
    tle_result_t got;
    tle_result_t want;
    if (rst) begin
      line_fill = 0;
      opt_edit  = 1'b1;
      opt_echo  = 1'b1;
      opt_crnl  = 1'b1;
      expected_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.channel     = m_axis_tuser;
        got.data_byte   = m_axis_tdata[BYTE_W-1:0];
        got.line_length = m_axis_tdata[BYTE_W +: LEN_W];
        got.last        = m_axis_tlast;
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected nothing, got ch=%0d byte=%02h len=%0d last=%0d",
                   $time, got.channel, got.data_byte, got.line_length, got.last);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: word mismatch, expected ch=%0d byte=%02h len=%0d last=%0d,",
                     $time, want.channel, want.data_byte, want.line_length, want.last);
            $display("%0t:   got ch=%0d byte=%02h len=%0d last=%0d",
                     $time, got.channel, got.data_byte, got.line_length, got.last);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_EDIT_ENABLE:   opt_edit = cfg_data;
          REG_ECHO_ENABLE:   opt_echo = cfg_data;
          REG_CR_TO_NEWLINE: opt_crnl = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_key(s_axis_tdata);
    end
    errors  <= fail_count;
    pending <= expected_words.size();
  end

endmodule

### tb/tty_line_editor_tb.sv
// testbench top of the terminal line editor: stimulus, option writes and verdict
module tty_line_editor_tb;
  import tle_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int DRAIN_CYCLES   = 64;    // covers a line kill that gives no word
  localparam int HOLD_CYCLES    = 300;   // long enough for the output side to back up
  localparam int IDLE_PCT       = 17;
  localparam int PHASE_KEYS     = 10;
  localparam int NUM_PHASES     = 7;
  // spare index, the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // one random phase: option settings and how the stimulus behaves
  typedef struct packed {
    logic edit;
    logic echo;
    logic crnl;
    logic overfill;  // start by running the store past full
    logic steady;    // no idling on either side
  } phase_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [BYTE_W-1:0]    s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic                 cfg_data      = 1'b0;

  int errors;
  int pending;
  bit no_idle  = 1'b0;
  int hold_seq = 0;

  // directed keys at reset settings: erase on an empty line, byte extremes,
  // erase, ctrl-z, reprint, both terminators
  logic [BYTE_W-1:0] opening_keys [10] = '{K_BS, 8'h00, 8'hFF, 8'h80, 8'h41,
                                           K_DEL, K_CTLZ, K_CTLR, K_CR, K_LF};

  phase_t phase_plan [NUM_PHASES] = '{
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0},  // bell with echo off
    '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0}
  };

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  tty_line_editor i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  tty_line_editor_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending)
  );

  // mostly printable text, with terminators, editing keys and any byte now and then
  function automatic logic [BYTE_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55)      return BYTE_W'($urandom_range(8'h7E, 8'h20));
    else if (roll < 62) return K_CR;
    else if (roll < 67) return K_LF;
    else if (roll < 74) return K_BS;
    else if (roll < 78) return K_DEL;
    else if (roll < 82) return K_CTLR;
    else if (roll < 86) return K_CTLU;
    else if (roll < 90) return K_CTLZ;
    else                return BYTE_W'($urandom_range(255));
  endfunction

  // offer one key, valid stays high straight into the next word unless a gap is drawn
  task automatic send_key(input logic [BYTE_W-1:0] key);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // let every predicted word come out, then give the sequencer time to settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // back-to-back writes of all three options plus a throwaway on the spare index
  task automatic write_options(input logic edit, input logic echo, input logic crnl);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EDIT_ENABLE;
    cfg_data  <= edit;
    @(posedge clk);
    cfg_index <= REG_ECHO_ENABLE;
    cfg_data  <= echo;
    @(posedge clk);
    cfg_index <= REG_CR_TO_NEWLINE;
    cfg_data  <= crnl;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= 1'($urandom_range(1));
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random back-pressure, plus one long hold each time hold_seq moves on
  initial begin : sink
    int seen_hold;
    seen_hold = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    foreach (opening_keys[i]) send_key(opening_keys[i]);

    // receiver holds off while a full line, a reprint and a line kill go in,
    // so the output backs up and the input stalls
    wait_drained();
    hold_seq <= hold_seq + 1;
    repeat (LINE_SIZE_DEF - 1) send_key(BYTE_W'($urandom_range(8'h7E, 8'h20)));
    send_key(K_CTLR);
    send_key(K_CTLU);

    // carriage return kept as typed
    wait_drained();
    write_options(1'b1, 1'b1, 1'b0);
    send_key(8'h61);
    send_key(K_CR);

    // editing switched off halfway through a line: raw byte flushes the lot
    send_key(8'h62);
    send_key(8'h63);
    send_key(8'h64);
    wait_drained();
    write_options(1'b0, 1'b1, 1'b1);
    send_key(8'h65);

    // random phases over the option settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_options(phase_plan[p].edit, phase_plan[p].echo, phase_plan[p].crnl);
      no_idle <= phase_plan[p].steady;
      if (phase_plan[p].overfill)
        repeat (LINE_SIZE_DEF - 1) send_key(BYTE_W'($urandom_range(8'h7E, 8'h20)));
      repeat (PHASE_KEYS) send_key(pick_key());
    end

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("[tty_line_editor] OK");
    end else begin
      $display("[tty_line_editor] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("[tty_line_editor] ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/tle_pkg.sv
rtl/tle_line_ram.sv
rtl/tle_out_stage.sv
rtl/tty_line_editor.sv
tb/tty_line_editor_checker.sv
tb/tty_line_editor_tb.sv
